/* hw/rtl/wbcc_pkg.sv */
// Shared types, constants and classification tables for the white balance classifier.
`timescale 1ns / 1ps
package wbcc_pkg;

  localparam int GAIN_FRAC_BITS = 8;
  localparam int PIX_W          = 8;
  localparam int GAIN_W         = 16;
  localparam int SUM_W          = 16;
  localparam int CNT_W          = 8;
  localparam int CLASS_W        = 4;
  localparam int NUM_W          = SUM_W + GAIN_FRAC_BITS;
  localparam int DIV_CNT_W      = $clog2(NUM_W);
  localparam int PROD_W         = PIX_W + GAIN_W;
  localparam int CFG_ADDR_W     = 1;
  localparam int CFG_DATA_W     = 8;
  localparam int S_TDATA_W      = 24;
  localparam int M_TDATA_W      = 32;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1 << GAIN_FRAC_BITS);
  localparam logic [GAIN_W-1:0] GAIN_MAX   = '1;

  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_COUNT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_LEVEL = 1'b1;

  localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = 8'd20;
  localparam logic [PIX_W-1:0] TARGET_LEVEL_RST = 8'd255;

  localparam logic [CLASS_W-1:0] CLASS_NONE = 4'd8;

  typedef struct packed {
    logic load;
    logic div_step;
    logic commit;
    logic mul;
    logic out_load;
  } wbcc_cmd_t;

  typedef struct packed {
    logic finish;
  } wbcc_sts_t;

  typedef logic [PIX_W-1:0] thr_t [8][3];

  localparam thr_t DEF_THR = '{
    '{8'd85, 8'd100, 8'd70},  '{8'd120, 8'd70, 8'd70},
    '{8'd90, 8'd130, 8'd90},  '{8'd100, 8'd100, 8'd125},
    '{8'd80, 8'd65, 8'd110},  '{8'd55, 8'd100, 8'd100},
    '{8'd90, 8'd90, 8'd90},   '{8'd70, 8'd70, 8'd70}};

  localparam thr_t CAL_THR = '{
    '{8'd255, 8'd255, 8'd200}, '{8'd255, 8'd200, 8'd200},
    '{8'd210, 8'd255, 8'd210}, '{8'd200, 8'd200, 8'd255},
    '{8'd255, 8'd200, 8'd255}, '{8'd200, 8'd255, 8'd255},
    '{8'd240, 8'd240, 8'd240}, '{8'd50, 8'd50, 8'd50}};

  // bit0 red, bit1 green, bit2 blue: set means at least, clear means at most
  localparam logic [2:0] GE_MASK [8] = '{3'h3, 3'h1, 3'h2, 3'h4, 3'h5, 3'h6, 3'h7, 3'h0};

  function automatic logic [CLASS_W-1:0] classify(input logic [PIX_W-1:0] px [3],
                                                  input logic cal);
    logic [CLASS_W-1:0] res;
    logic               hit;
    logic [PIX_W-1:0]   thr;
    res = CLASS_NONE;
    for (int k = 7; k >= 0; k--) begin
      hit = 1'b1;
      for (int c = 0; c < 3; c++) begin
        thr = cal ? CAL_THR[k][c] : DEF_THR[k][c];
        if (GE_MASK[k][c] ? (px[c] < thr) : (px[c] > thr)) hit = 1'b0;
      end
      if (hit) res = CLASS_W'(k);
    end
    return res;
  endfunction

endpackage

/* hw/rtl/wbcc_ctrl.sv */
// Controller state machine sequencing accept, gain division, correction and output.
`timescale 1ns / 1ps
module wbcc_ctrl import wbcc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  output logic      m_tvalid_o,
  input  logic      m_tready_i,
  input  wbcc_sts_t sts_i,
  output wbcc_cmd_t cmd_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_MUL, ST_CLS} state_e;

  state_e               state_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 m_tvalid_q;
  logic                 m_tvalid_d;
  logic                 out_free;

  assign out_free   = !m_tvalid_q || m_tready_i;
  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = m_tvalid_q;
  assign m_tvalid_d = ((state_q == ST_CLS) && out_free) ? 1'b1 :
                      (m_tready_i ? 1'b0 : m_tvalid_q);

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_IDLE) && s_tvalid_i;
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.commit   = (state_q == ST_DIV) && (cnt_q == '0);
    cmd_o.mul      = (state_q == ST_MUL);
    cmd_o.out_load = (state_q == ST_CLS) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      m_tvalid_q <= m_tvalid_d;
      case (state_q)
        ST_IDLE: begin
          if (s_tvalid_i) begin
            if (sts_i.finish) begin
              state_q <= ST_DIV;
              cnt_q   <= DIV_CNT_W'(NUM_W - 1);
            end else begin
              state_q <= ST_MUL;
            end
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) state_q <= ST_MUL;
        end
        ST_MUL: state_q <= ST_CLS;
        ST_CLS: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/wbcc_dp.sv */
// Datapath: calibration sums, serial gain dividers, gain multipliers and classifier.
`timescale 1ns / 1ps
module wbcc_dp import wbcc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [S_TDATA_W-1:0]  s_data_i,
  input  logic                  start_i,
  input  logic                  restore_i,
  input  wbcc_cmd_t             cmd_i,
  output wbcc_sts_t             sts_o,
  output logic [M_TDATA_W-1:0]  m_data_o,
  output logic                  done_o,
  output logic                  mode_o
);

  logic [CNT_W-1:0]  sample_count_q;
  logic [PIX_W-1:0]  target_level_q;
  logic [SUM_W-1:0]  sums_q [3];
  logic [CNT_W-1:0]  taken_q;
  logic              calibrating_q;
  logic              calibrated_q;
  logic [GAIN_W-1:0] gains_q [3];
  logic [PIX_W-1:0]  raw_q [3];
  logic              restore_q;
  logic              done_q;
  logic [SUM_W-1:0]  div_q [3];
  logic [NUM_W-1:0]  quo_q [3];
  logic [SUM_W:0]    rem_q [3];
  logic [PIX_W-1:0]  px_q [3];
  logic [M_TDATA_W-1:0] out_data_q;
  logic              out_done_q;
  logic              out_mode_q;

  logic              start_eff;
  logic              cal_eff;
  logic [CNT_W-1:0]  taken_eff;
  logic              finish;
  logic [PIX_W-1:0]  raw [3];
  logic [NUM_W-1:0]  numer;

  assign raw[0] = s_data_i[7:0];
  assign raw[1] = s_data_i[15:8];
  assign raw[2] = s_data_i[23:16];

  assign start_eff = !calibrating_q && start_i;
  assign cal_eff   = calibrating_q || start_i;
  assign taken_eff = start_eff ? '0 : taken_q;
  assign finish    = cal_eff && (taken_eff >= sample_count_q);
  assign sts_o.finish = finish;
  assign numer     = NUM_W'({(NUM_W-GAIN_FRAC_BITS)'(target_level_q) *
                             (NUM_W-GAIN_FRAC_BITS)'(taken_eff), GAIN_FRAC_BITS'(0)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= SAMPLE_COUNT_RST;
      target_level_q <= TARGET_LEVEL_RST;
      taken_q        <= '0;
      calibrating_q  <= 1'b0;
      calibrated_q   <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        sums_q[c]  <= '0;
        gains_q[c] <= UNITY_GAIN;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_SAMPLE_COUNT: sample_count_q <= cfg_wdata_i;
          REG_TARGET_LEVEL: target_level_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        if (finish) begin
          taken_q       <= '0;
          calibrating_q <= 1'b0;
          for (int c = 0; c < 3; c++) sums_q[c] <= '0;
        end else if (cal_eff) begin
          calibrating_q <= 1'b1;
          taken_q       <= taken_eff + 1'b1;
          for (int c = 0; c < 3; c++) begin
            logic [SUM_W:0] s;
            s = (start_eff ? {(SUM_W+1){1'b0}} : {1'b0, sums_q[c]}) + (SUM_W+1)'(raw[c]);
            sums_q[c] <= s[SUM_W] ? '1 : s[SUM_W-1:0];
          end
        end
        if (restore_i && !finish) begin
          calibrated_q <= 1'b0;
          for (int c = 0; c < 3; c++) gains_q[c] <= UNITY_GAIN;
        end
      end
      if (cmd_i.commit) begin
        calibrated_q <= !restore_q;
        for (int c = 0; c < 3; c++) begin
          logic [NUM_W-1:0] q;
          q = {quo_q[c][NUM_W-2:0], 1'b0};
          if ({rem_q[c][SUM_W-1:0], quo_q[c][NUM_W-1]} >= {1'b0, div_q[c]}) q[0] = 1'b1;
          if (restore_q) gains_q[c] <= UNITY_GAIN;
          else gains_q[c] <= (|q[NUM_W-1:GAIN_W]) ? GAIN_MAX : q[GAIN_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      restore_q <= restore_i;
      done_q    <= finish;
      for (int c = 0; c < 3; c++) begin
        raw_q[c] <= raw[c];
        div_q[c] <= start_eff ? '0 : sums_q[c];
        quo_q[c] <= numer;
        rem_q[c] <= '0;
      end
    end
    if (cmd_i.div_step) begin
      for (int c = 0; c < 3; c++) begin
        logic [SUM_W:0] r;
        r = {rem_q[c][SUM_W-1:0], quo_q[c][NUM_W-1]};
        if (r >= {1'b0, div_q[c]}) begin
          rem_q[c] <= r - {1'b0, div_q[c]};
          quo_q[c] <= {quo_q[c][NUM_W-2:0], 1'b1};
        end else begin
          rem_q[c] <= r;
          quo_q[c] <= {quo_q[c][NUM_W-2:0], 1'b0};
        end
      end
    end
    if (cmd_i.mul) begin
      for (int c = 0; c < 3; c++) begin
        logic [PROD_W-1:0] p;
        p = PROD_W'(raw_q[c]) * PROD_W'(gains_q[c]);
        px_q[c] <= (|p[PROD_W-1:GAIN_FRAC_BITS+PIX_W]) ? '1 : p[GAIN_FRAC_BITS +: PIX_W];
      end
    end
    if (cmd_i.out_load) begin
      out_data_q <= {(M_TDATA_W-3*PIX_W-CLASS_W)'(0), classify(px_q, calibrated_q),
                     px_q[2], px_q[1], px_q[0]};
      out_done_q <= done_q;
      out_mode_q <= calibrated_q;
    end
  end

  assign m_data_o = out_data_q;
  assign done_o   = out_done_q;
  assign mode_o   = out_mode_q;

endmodule

/* hw/rtl/white_balance_color_classifier.sv */
// Top level of the gray-world white balance and color classifier.
`timescale 1ns / 1ps
// Usage:
//   Slave stream carries one raw RGB sample per transaction, tuser holds the
//   start-calibration and restore-default flags. Master stream returns one
//   corrected pixel with its color class per transaction; tuser holds the
//   calibration-done and calibrated-mode flags.
//   sample_count and target_level are written through cfg_we_i/cfg_addr_i; the user
//   must write them only while the block is idle, which the block does not enforce.
//   An ordinary sample passes through the accept, multiply and classify states
//   before output valid. A sample that finishes a calibration first runs three
//   restoring dividers in parallel, one quotient bit per cycle, before the
//   multiply state.
//   The controller handles one sample at a time and takes no new sample
//   until it is back in idle.
//   s_axis_tready is high whenever the controller is idle; a finished result
//   sits in the output register, so the next sample is taken while the
//   receiver stalls, and that sample then waits before output until the
//   register frees.
//   Reset restores unity gains, clears calibration state, loads the
//   register defaults (20 samples, level 255) and empties the output.
module white_balance_color_classifier import wbcc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // red_in, green_in, blue_in
  input  logic [1:0]            s_axis_tuser,  // start_calibration, restore_default
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // red_out, green_out, blue_out, color_class, zero pad
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  output logic [1:0]            m_axis_tuser   // calibration_done, calibrated_mode
);

  wbcc_cmd_t cmd;
  wbcc_sts_t sts;

  wbcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wbcc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_data_i    (s_axis_tdata),
    .start_i     (s_axis_tuser[0]),
    .restore_i   (s_axis_tuser[1]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_data_o    (m_axis_tdata),
    .done_o      (m_axis_tuser[0]),
    .mode_o      (m_axis_tuser[1])
  );

endmodule

/* hw/rtl/wbcc_checker.sv */
// Port-level checker for the white balance classifier and its bind.
`timescale 1ns / 1ps
module wbcc_checker import wbcc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [S_TDATA_W-1:0]  s_axis_tdata,
  input logic [1:0]            s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [M_TDATA_W-1:0]  m_axis_tdata,
  input logic [1:0]            m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transaction dropped while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transaction accepted while busy");

  a_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[27:24] <= CLASS_NONE)
    else $error("color class out of range");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[31:28] == 4'd0)
    else $error("pad bits not zero");

endmodule

bind white_balance_color_classifier wbcc_checker u_wbcc_checker (.*);
